// ===== src/glc_pkg.sv =====
`default_nettype none
package glc_pkg;

	localparam int VALUE_BITS_DEF = 10;
	localparam int MAX_ITEMS_DEF  = 1024;
	localparam int GAP_BITS       = 10;
	localparam int FIELD_BITS     = 11;

	typedef struct packed {
		logic [GAP_BITS-1:0] value;
		logic                last;
	} in_word_t;

	typedef struct packed {
		logic [FIELD_BITS-1:0] item_index;
		logic [FIELD_BITS-1:0] chain_length;
		logic [FIELD_BITS-1:0] predecessor_index;
		logic [FIELD_BITS-1:0] best_length;
		logic [FIELD_BITS-1:0] best_end_index;
		logic                  overflow;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UP,
		ST_LOW,
		ST_WAIT,
		ST_CALC,
		ST_INS,
		ST_OUT
	} state_t;

endpackage
`default_nettype wire

// ===== src/glc_mem.sv =====
`default_nettype none
module glc_mem #(
	parameter int AW = 11,
	parameter int DW = 22
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);
	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== src/gap_constrained_longest_chain_dp.sv =====
`default_nettype none
// Longest chain with a minimum step: each value word yields one result word with its index,
// the longest chain ending there (adjacent values at least min_gap apart), the predecessor
// and the running best. A max tree of 2^(VALUE_BITS+1) nodes sits in one node memory with
// one read and one write port. From one accept to the next an item goes through the accept,
// a walk of up to VALUE_BITS+1 node reads for the range from value+min_gap, another of up to
// VALUE_BITS+1 for the range up to value-min_gap, a settle state and a pick state,
// VALUE_BITS+1 pipelined read-modify-write steps from leaf to root, and an output state
// that lasts as long as out_stall holds it; in_stall is high from the accept until the
// result word is taken. After reset and after each word marked last the node memory is
// swept to zero, one node a cycle over all 2^(VALUE_BITS+1) nodes, with in_stall high;
// min_gap writes are taken at any time.
module gap_constrained_longest_chain_dp #(
	parameter int VALUE_BITS = glc_pkg::VALUE_BITS_DEF,
	parameter int MAX_ITEMS  = glc_pkg::MAX_ITEMS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire glc_pkg::in_word_t in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output glc_pkg::out_word_t    out_data,
	input  wire logic             cfg_we,
	input  wire logic [glc_pkg::GAP_BITS-1:0] cfg_wdata
);
	import glc_pkg::*;

	localparam int VB = VALUE_BITS;
	localparam int AW = VB + 1;
	localparam int LW = $clog2(MAX_ITEMS + 1);
	localparam int DW = $clog2(VB + 1);
	localparam int W  = ((VB > GAP_BITS) ? VB : GAP_BITS) + 2;
	localparam logic [DW-1:0] VB_D   = DW'(VB);
	localparam logic [LW-1:0] MAX_L  = LW'(MAX_ITEMS);
	localparam logic [W-1:0]  TOP_W  = W'((2 ** VB) - 1);

	state_t state_q, state_d;

	logic [GAP_BITS-1:0] gap_q;
	logic [LW-1:0] cnt_q, best_len_q, best_end_q, len_q, pred_q;
	logic          ovf_q, last_q, up_ok_q, low_ok_q;
	logic [VB-1:0] a_q, b_q;
	logic [LW-1:0] up_len_q, up_idx_q, lo_len_q, lo_idx_q;
	logic [DW-1:0] d_q;
	logic [AW-1:0] node_q, node_s1, clr_q;
	logic          take_s1, pre_s1, ins_s1;

	// memory
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [2*LW-1:0] wdata, rdata;
	logic [LW-1:0] rd_len, rd_idx;

	glc_mem #(.AW(AW), .DW(2*LW)) u_mem (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rd_len = rdata[2*LW-1:LW];
	assign rd_idx = rdata[LW-1:0];

	// input value and gap arithmetic
	logic [VB+GAP_BITS-1:0] v_ext;
	logic [VB-1:0] vv;
	logic [W-1:0]  vw, gw, sum_w, dif_w;
	assign v_ext = {{VB{1'b0}}, in_data.value};
	assign vv    = v_ext[VB-1:0];
	assign vw    = {{(W-VB){1'b0}}, vv};
	assign gw    = {{(W-GAP_BITS){1'b0}}, gap_q};
	assign sum_w = vw + gw;
	assign dif_w = vw - gw;

	// shared walk unit: one tree level per cycle
	logic          pre;
	logic [VB-1:0] key;
	logic [AW-1:0] ext, lowmask, lowbits, node_at, child;
	logic [DW-1:0] sh;
	logic          full, walk_take, walk_done;
	logic [AW-1:0] walk_addr;

	always_comb begin
		pre       = (state_q == ST_LOW);
		key       = pre ? a_q : b_q;
		ext       = {1'b1, key};
		sh        = VB_D - d_q;
		lowmask   = ~({AW{1'b1}} << sh);
		lowbits   = ext & lowmask;
		node_at   = ext >> sh;
		child     = ext >> (sh - 1'b1);
		full      = pre ? (lowbits == lowmask) : (lowbits == '0);
		walk_done = full;
		walk_take = 1'b0;
		walk_addr = node_at;
		if (full) begin
			walk_take = 1'b1;
		end else if (pre && child[0]) begin
			walk_take = 1'b1;
			walk_addr = {child[AW-1:1], 1'b0};
		end else if (!pre && !child[0]) begin
			walk_take = 1'b1;
			walk_addr = {child[AW-1:1], 1'b1};
		end
	end

	logic active_walk;
	logic in_acc, out_acc;
	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// pick and saturate
	logic [LW-1:0] pick_len, pick_idx, len_c;
	logic [LW:0]   lenp1;
	always_comb begin
		if (lo_len_q > up_len_q) begin
			pick_len = lo_len_q;
			pick_idx = lo_idx_q;
		end else begin
			pick_len = up_len_q;
			pick_idx = up_idx_q;
		end
		lenp1 = {1'b0, pick_len} + 1'b1;
		len_c = (lenp1 > {1'b0, MAX_L}) ? MAX_L : lenp1[LW-1:0];
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_stall    = 1'b1;
		out_valid   = 1'b0;
		active_walk = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				if (clr_q == {AW{1'b1}}) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) state_d = ST_UP;
			end
			ST_UP: begin
				if (!up_ok_q) begin
					state_d = ST_LOW;
				end else begin
					active_walk = 1'b1;
					if (walk_done) state_d = ST_LOW;
				end
			end
			ST_LOW: begin
				if (!low_ok_q) begin
					state_d = ST_WAIT;
				end else begin
					active_walk = 1'b1;
					if (walk_done) state_d = ST_WAIT;
				end
			end
			ST_WAIT: state_d = ST_CALC;
			ST_CALC: state_d = ST_INS;
			ST_INS: begin
				if (node_q == AW'(1)) state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = last_q ? ST_CLEAR : ST_IDLE;
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		raddr = (state_q == ST_INS) ? node_q : walk_addr;
		if (state_q == ST_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else begin
			we    = ins_s1 && (rd_len < len_q);
			waddr = node_s1;
			wdata = {len_q, cnt_q};
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q      <= GAP_BITS'(1);
			cnt_q      <= '0;
			best_len_q <= '0;
			best_end_q <= '0;
			ovf_q      <= 1'b0;
			d_q        <= '0;
			clr_q      <= '0;
			take_s1    <= 1'b0;
			ins_s1     <= 1'b0;
		end else begin
			if (cfg_we) gap_q <= cfg_wdata;
			take_s1 <= active_walk && walk_take;
			ins_s1  <= (state_q == ST_INS);
			if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			else clr_q <= '0;
			if (active_walk && !walk_done) d_q <= d_q + 1'b1;
			else if (state_q != ST_UP && state_q != ST_LOW) d_q <= '0;
			else if (walk_done || state_d != state_q) d_q <= '0;
			if (in_acc) begin
				if (cnt_q < MAX_L) cnt_q <= cnt_q + 1'b1;
				else ovf_q <= 1'b1;
			end
			if (state_q == ST_CALC && len_c > best_len_q) begin
				best_len_q <= len_c;
				best_end_q <= cnt_q;
			end
			if (out_acc && last_q) begin
				cnt_q      <= '0;
				best_len_q <= '0;
				best_end_q <= '0;
				ovf_q      <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		pre_s1 <= pre;
		if (in_acc) begin
			last_q   <= in_data.last;
			low_ok_q <= (vw >= gw);
			up_ok_q  <= (sum_w <= TOP_W);
			a_q      <= dif_w[VB-1:0];
			b_q      <= sum_w[VB-1:0];
			node_q   <= {1'b1, vv};
			up_len_q <= '0;
			up_idx_q <= '0;
			lo_len_q <= '0;
			lo_idx_q <= '0;
		end else begin
			// rightmost node wins a tie
			if (take_s1 && pre_s1 && rd_len >= lo_len_q) begin
				lo_len_q <= rd_len;
				lo_idx_q <= rd_idx;
			end
			if (take_s1 && !pre_s1 && rd_len > up_len_q) begin
				up_len_q <= rd_len;
				up_idx_q <= rd_idx;
			end
			if (state_q == ST_INS) node_q <= node_q >> 1;
		end
		node_s1 <= node_q;
		if (state_q == ST_CALC) begin
			len_q  <= len_c;
			pred_q <= pick_idx;
		end
	end

	// output word
	logic [LW+FIELD_BITS-1:0] o_idx, o_len, o_pred, o_best, o_end;
	assign o_idx  = {{FIELD_BITS{1'b0}}, cnt_q};
	assign o_len  = {{FIELD_BITS{1'b0}}, len_q};
	assign o_pred = {{FIELD_BITS{1'b0}}, pred_q};
	assign o_best = {{FIELD_BITS{1'b0}}, best_len_q};
	assign o_end  = {{FIELD_BITS{1'b0}}, best_end_q};

	always_comb begin
		out_data.item_index        = o_idx[FIELD_BITS-1:0];
		out_data.chain_length      = o_len[FIELD_BITS-1:0];
		out_data.predecessor_index = o_pred[FIELD_BITS-1:0];
		out_data.best_length       = o_best[FIELD_BITS-1:0];
		out_data.best_end_index    = o_end[FIELD_BITS-1:0];
		out_data.overflow          = ovf_q;
	end

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (len_q != '0))
		else $error("chain length zero on output");

	a_best_covers: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (best_len_q >= len_q))
		else $error("running best below chain length");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |=> !out_valid)
		else $error("result repeated");

	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UP || state_q == ST_LOW) |-> !we)
		else $error("node write during range walk");

endmodule
`default_nettype wire

// ===== tb/sv/gap_constrained_longest_chain_dp_tb.sv =====
`default_nettype none
module gap_constrained_longest_chain_dp_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import glc_pkg::*;

	localparam int VBITS = VALUE_BITS_DEF;
	localparam int MAXN  = MAX_ITEMS_DEF;
	localparam int DTOP  = (1 << VBITS) - 1;
	localparam int NODES = 2 << VBITS;
	localparam int SWEEP = NODES + 16;
	localparam int CYCLE_LIMIT = 3000000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_word_t out_data;
	logic      cfg_we = 1'b0;
	logic [GAP_BITS-1:0] cfg_wdata = '0;

	gap_constrained_longest_chain_dp u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	// chain predictor state
	int unsigned node_len [NODES];
	int unsigned node_idx [NODES];
	int unsigned seq_count, top_len, top_end, ovf, gap_m;
	out_word_t   expected_words[$];
	int          errors = 0;
	int          cycles = 0;
	int          send_idle_pct = 0, recv_stall_pct = 0;

	function automatic void clear_chain();
		for (int i = 0; i < NODES; i++) begin
			node_len[i] = 0;
			node_idx[i] = 0;
		end
		seq_count = 0;
		top_len = 0;
		top_end = 0;
		ovf = 0;
	endfunction

	function automatic void range_max(int unsigned node, int unsigned lo, int unsigned hi,
			int unsigned qlo, int unsigned qhi, output int unsigned l, output int unsigned ix);
		int unsigned mid, l1, i1, l2, i2;
		if (qlo == lo && qhi == hi) begin
			l = node_len[node];
			ix = node_idx[node];
		end else begin
			mid = (lo + hi) >> 1;
			if (qhi <= mid) range_max(2*node, lo, mid, qlo, qhi, l, ix);
			else if (qlo > mid) range_max(2*node+1, mid+1, hi, qlo, qhi, l, ix);
			else begin
				range_max(2*node, lo, mid, qlo, mid, l1, i1);
				range_max(2*node+1, mid+1, hi, mid+1, qhi, l2, i2);
				// upper half wins ties
				if (l1 > l2) begin l = l1; ix = i1; end
				else begin l = l2; ix = i2; end
			end
		end
	endfunction

	function automatic out_word_t chain_step(in_word_t w);
		int unsigned v, ll, li, ul, ui, pl, pi, len, n;
		out_word_t r;
		v = w.value;
		ll = 0; li = 0; ul = 0; ui = 0;
		if (seq_count < MAXN) seq_count++;
		else ovf = 1;
		if (v >= gap_m) range_max(1, 0, DTOP, 0, v - gap_m, ll, li);
		if (v + gap_m <= DTOP) range_max(1, 0, DTOP, v + gap_m, DTOP, ul, ui);
		if (ll > ul) begin pl = ll; pi = li; end
		else begin pl = ul; pi = ui; end
		len = pl + 1;
		if (len > MAXN) len = MAXN;
		n = (1 << VBITS) + v;
		while (n >= 1) begin
			if (node_len[n] < len) begin
				node_len[n] = len;
				node_idx[n] = seq_count;
			end
			n >>= 1;
		end
		if (len > top_len) begin
			top_len = len;
			top_end = seq_count;
		end
		r.item_index = seq_count[FIELD_BITS-1:0];
		r.chain_length = len[FIELD_BITS-1:0];
		r.predecessor_index = pi[FIELD_BITS-1:0];
		r.best_length = top_len[FIELD_BITS-1:0];
		r.best_end_index = top_end[FIELD_BITS-1:0];
		r.overflow = ovf[0];
		if (w.last) clear_chain();
		return r;
	endfunction

	task automatic send_word(input logic [9:0] v, input logic lst);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		in_data <= '{value: v, last: lst};
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_words.push_back(chain_step('{value: v, last: lst}));
		@(negedge clk);
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		while (expected_words.size() != 0) @(negedge clk);
		repeat (SWEEP + 64) @(negedge clk);
	endtask

	task automatic set_gap(input int unsigned g);
		drain();
		cfg_wdata <= g[GAP_BITS-1:0];
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		gap_m = g;
	endtask

	always @(negedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$error("unexpected result word");
				errors++;
			end else begin
				out_word_t e;
				e = expected_words.pop_front();
				if (out_data.item_index !== e.item_index) begin
					$error("item_index exp %0d got %0d", e.item_index, out_data.item_index);
					errors++;
				end
				if (out_data.chain_length !== e.chain_length) begin
					$error("chain_length exp %0d got %0d", e.chain_length,
						out_data.chain_length);
					errors++;
				end
				if (out_data.predecessor_index !== e.predecessor_index) begin
					$error("predecessor_index exp %0d got %0d", e.predecessor_index,
						out_data.predecessor_index);
					errors++;
				end
				if (out_data.best_length !== e.best_length) begin
					$error("best_length exp %0d got %0d", e.best_length, out_data.best_length);
					errors++;
				end
				if (out_data.best_end_index !== e.best_end_index) begin
					$error("best_end_index exp %0d got %0d", e.best_end_index,
						out_data.best_end_index);
					errors++;
				end
				if (out_data.overflow !== e.overflow) begin
					$error("overflow exp %0d got %0d", e.overflow, out_data.overflow);
					errors++;
				end
			end
		end
	end

	task automatic test_directed();
		send_word(10'd0, 1'b0);
		send_word(10'd1023, 1'b0);
		send_word(10'd512, 1'b0);
		send_word(10'd512, 1'b0);
		send_word(10'd511, 1'b0);
		send_word(10'd0, 1'b0);
		send_word(10'd1023, 1'b1);
		set_gap(0);
		send_word(10'd5, 1'b0);
		send_word(10'd5, 1'b0);
		send_word(10'd3, 1'b1);
		set_gap(1023);
		send_word(10'd0, 1'b0);
		send_word(10'd1023, 1'b0);
		send_word(10'd0, 1'b0);
		send_word(10'd500, 1'b1);
		set_gap(600);
		send_word(10'd700, 1'b0);
		send_word(10'd400, 1'b0);
		send_word(10'd599, 1'b0);
		send_word(10'd1000, 1'b1);
	endtask

	// runs one sequence past capacity so the index saturates
	task automatic test_overflow();
		set_gap(0);
		for (int i = 0; i < MAXN + 6; i++)
			send_word(10'($urandom_range(DTOP)), i == MAXN + 5);
	endtask

	task automatic test_random(input int n_words, input int idle, input int stall);
		int left;
		send_idle_pct = idle;
		recv_stall_pct = stall;
		left = n_words;
		while (left > 0) begin
			int len;
			len = $urandom_range(1, 60);
			if (len > left) len = left;
			for (int i = 0; i < len; i++) begin
				logic [9:0] v;
				v = ($urandom_range(3) == 0) ? 10'($urandom_range(DTOP))
					: 10'($urandom_range(200) + 400);
				send_word(v, i == len - 1);
			end
			left -= len;
		end
	endtask

	initial begin
		gap_m = 1;
		clear_chain();
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		set_gap(1);
		test_random(200, 0, 0);
		set_gap(37);
		test_random(200, 52, 0);
		set_gap(3);
		test_random(200, 0, 52);
		set_gap(120);
		test_random(200, 20, 20);
		set_gap(0);
		test_random(100, 0, 0);
		test_overflow();
		set_gap(1023);
		test_random(60, 20, 20);
		drain();
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
`default_nettype wire
